@@ rtl/core/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;
  localparam int UNIT_W = 26;
  localparam int ADDR_W = 32;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;
  localparam logic [31:0] MAX_REQUEST = 32'hFFFF_FFC0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_HIT,
    OP_MARK,
    OP_APPEND,
    OP_SPLIT,
    OP_SHIFT_UP,
    OP_MERGE,
    OP_SHIFT_DN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic hit_exact;
    logic full;
    logic append_ok;
    logic shift_done;
    logic is_free;
    logic zero_addr;
    logic oversize;
    logic prev_free;
    logic last_entry;
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator. Requests arrive on s_axis (tdata = size or address,
// tuser = 0 allocate / 1 release); one result per request leaves on m_axis.
// One request at a time: it walks the segment table one entry per cycle, then
// shifts the tail of the table one entry per cycle for a split or a merge, and
// then presents the result; the next request is taken the cycle after the result
// transfer.
// Write heap_base only while idle.
`default_nettype none
module first_fit_heap_allocator_unit #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // request_value
  input  wire logic        s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // result_address
  output logic             m_axis_tuser    // status_ok
);
  logic [31:0] heap_base;
  ffha_pkg::cmd_t cmd;
  ffha_pkg::stat_t stat;
  logic res_load, res_ok, res_use_addr;
  logic [31:0] dp_addr, res_addr;

  always_ff @(posedge clk) begin
    if (rst) heap_base <= '0;
    else if (cfg_we) heap_base <= cfg_wdata;
    if (res_load) res_addr <= dp_addr;
  end

  ffha_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk, .rst, .heap_base, .cmd_in(s_axis_tuser), .value_in(s_axis_tdata),
    .cmd, .stat, .addr_out(dp_addr)
  );

  ffha_control u_ctl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .stat, .cmd,
    .res_load, .res_ok, .res_use_addr
  );

  assign m_axis_tdata = res_use_addr ? res_addr : 32'd0;
  assign m_axis_tuser = res_ok;
endmodule
`default_nettype wire

@@ rtl/core/ffha_datapath.sv @@
`default_nettype none
module ffha_datapath #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [31:0]       heap_base,
  input  wire logic              cmd_in,
  input  wire logic [31:0]       value_in,
  input  wire ffha_pkg::cmd_t    cmd,
  output ffha_pkg::stat_t        stat,
  output logic [31:0]            addr_out
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int UW = ffha_pkg::UNIT_W;

  // each entry holds {in_use, units}
  logic [UW:0]   seg_mem [MAX_SEGMENTS];
  logic [UW:0]   rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [UW:0]   wr_data;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] j;
  logic [32:0]   addr;
  logic [UW-1:0] want;
  logic [UW-1:0] hit_units;
  logic [UW-1:0] prev_units;
  logic          free_cmd;
  logic [31:0]   target;
  logic          prev_used;
  logic [UW-1:0] cur_units;
  logic          cur_used;
  logic [33:0]   app_end;

  assign cur_units = rd_data[UW-1:0];
  assign cur_used = rd_data[UW];
  assign app_end = {1'b0, addr} + {2'b00, want, 6'd0};
  assign addr_out = addr[31:0];

  always_comb begin
    stat.scan_end = (idx >= count);
    stat.is_free = free_cmd;
    stat.zero_addr = (target == 32'd0);
    stat.oversize = (target > ffha_pkg::MAX_REQUEST);
    stat.full = (count >= CW'(MAX_SEGMENTS));
    stat.append_ok = (app_end < 34'h1_0000_0000);
    stat.prev_free = (idx != '0) && !prev_used;
    stat.last_entry = ((idx + CW'(1)) >= count);
    if (free_cmd) begin
      stat.hit = cur_used && (addr == {1'b0, target});
    end else begin
      stat.hit = !cur_used && (cur_units >= want);
    end
    stat.hit_exact = (cur_units == want);
    if (cmd.op == ffha_pkg::OP_SHIFT_DN) stat.shift_done = ((j + CW'(1)) >= count);
    else stat.shift_done = (j == (idx + CW'(2)));
  end

  always_comb begin
    unique case (cmd.op)
      ffha_pkg::OP_LOAD: rd_addr = '0;
      ffha_pkg::OP_SCAN, ffha_pkg::OP_MERGE: rd_addr = IW'(idx + CW'(1));
      ffha_pkg::OP_HIT: rd_addr = IW'(count - CW'(1));
      ffha_pkg::OP_SHIFT_UP: rd_addr = IW'(j - CW'(2));
      ffha_pkg::OP_SHIFT_DN: rd_addr = IW'(j + CW'(2));
      default: rd_addr = IW'(idx);
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = IW'(idx);
    wr_data = rd_data;
    unique case (cmd.op)
      ffha_pkg::OP_MARK: begin
        wr_en = 1'b1;
        wr_data = free_cmd ? {1'b0, hit_units} : {1'b1, want};
      end
      ffha_pkg::OP_APPEND: begin
        wr_en = 1'b1;
        wr_addr = IW'(count);
        wr_data = {1'b1, want};
      end
      ffha_pkg::OP_SPLIT: begin
        wr_en = 1'b1;
        wr_addr = IW'(idx + CW'(1));
        wr_data = {1'b0, hit_units - want};
      end
      ffha_pkg::OP_SHIFT_UP, ffha_pkg::OP_SHIFT_DN: begin
        wr_en = 1'b1;
        wr_addr = IW'(j);
      end
      ffha_pkg::OP_MERGE: begin
        wr_en = 1'b1;
        wr_addr = IW'(idx - CW'(1));
        wr_data = {1'b0, prev_units + hit_units};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) seg_mem[wr_addr] <= wr_data;
    rd_data <= seg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.op)
        ffha_pkg::OP_LOAD: begin
          free_cmd <= cmd_in;
          target <= value_in;
          want <= (value_in[31:6] == '0) ? UW'(1)
                  : value_in[31:6] + UW'(value_in[5:0] != 6'd0);
          addr <= {1'b0, heap_base};
          idx <= '0;
          prev_used <= 1'b1;
        end
        ffha_pkg::OP_SCAN: begin
          addr <= addr + {1'b0, cur_units, 6'd0};
          prev_used <= cur_used;
          prev_units <= cur_units;
          idx <= idx + CW'(1);
        end
        ffha_pkg::OP_HIT: begin
          hit_units <= cur_units;
          j <= count;
        end
        ffha_pkg::OP_SHIFT_UP: j <= j - CW'(1);
        ffha_pkg::OP_SPLIT: count <= count + CW'(1);
        ffha_pkg::OP_APPEND: count <= count + CW'(1);
        ffha_pkg::OP_MERGE: begin
          j <= idx;
          count <= count - CW'(1);
        end
        ffha_pkg::OP_SHIFT_DN: j <= j + CW'(1);
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/ffha_control.sv @@
`default_nettype none
module ffha_control (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t       cmd,
  output logic                 res_load,
  output logic                 res_ok,
  output logic                 res_use_addr
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_SCAN = 4'd2, S_SHUP = 4'd3,
                         S_SPLIT = 4'd4, S_MARK = 4'd5, S_SHDN = 4'd6, S_OUT = 4'd7,
                         S_MERGE = 4'd8;
  logic [3:0] state, state_next;
  logic ok_next, use_next;

  always_comb begin
    state_next = state;
    cmd.op = ffha_pkg::OP_NONE;
    res_load = 1'b0;
    ok_next = 1'b0;
    use_next = 1'b0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.op = ffha_pkg::OP_LOAD;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_free ? stat.zero_addr : stat.oversize) begin
          res_load = 1'b1; ok_next = stat.is_free; state_next = S_OUT;
        end else state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          res_load = 1'b1;
          if (!stat.is_free && !stat.full && stat.append_ok) begin
            cmd.op = ffha_pkg::OP_APPEND; ok_next = 1'b1; use_next = 1'b1;
          end
          state_next = S_OUT;
        end else if (stat.hit) begin
          cmd.op = ffha_pkg::OP_HIT;
          res_load = 1'b1;
          if (stat.is_free) begin
            ok_next = 1'b1;
            state_next = stat.prev_free ? S_MERGE : S_MARK;
          end else if (stat.hit_exact) begin
            ok_next = 1'b1; use_next = 1'b1; state_next = S_MARK;
          end else if (stat.full) begin
            state_next = S_OUT;
          end else begin
            ok_next = 1'b1; use_next = 1'b1;
            state_next = stat.last_entry ? S_SPLIT : S_SHUP;
          end
        end else cmd.op = ffha_pkg::OP_SCAN;
      end
      S_SHUP: begin
        cmd.op = ffha_pkg::OP_SHIFT_UP;
        if (stat.shift_done) state_next = S_SPLIT;
      end
      S_SPLIT: begin cmd.op = ffha_pkg::OP_SPLIT; state_next = S_MARK; end
      S_MARK: begin cmd.op = ffha_pkg::OP_MARK; state_next = S_OUT; end
      S_MERGE: begin
        cmd.op = ffha_pkg::OP_MERGE;
        state_next = stat.last_entry ? S_OUT : S_SHDN;
      end
      S_SHDN: begin
        cmd.op = ffha_pkg::OP_SHIFT_DN;
        if (stat.shift_done) state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_ok <= 1'b0;
      res_use_addr <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_ok <= ok_next;
        res_use_addr <= use_next;
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/first_fit_heap_allocator_unit_checker.sv @@
`default_nettype none
module first_fit_heap_allocator_unit_checker #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [ffha_pkg::ADDR_W-1:0] addr;
    logic                        ok;
  } heap_reply_t;

  heap_reply_t                  reply_q[$];
  logic [31:0]                  heap_base;
  logic [ffha_pkg::UNIT_W-1:0]  seg_units[MAX_SEGMENTS];
  logic                         seg_used[MAX_SEGMENTS];
  int                           seg_count;

  function automatic heap_reply_t alloc_segment(logic [31:0] size);
    heap_reply_t r;
    logic [63:0] addr;
    logic [63:0] need;
    r = '0;
    addr = {32'b0, heap_base};
    if (size > ffha_pkg::MAX_REQUEST) return r;
    need = ({32'b0, size} + 64'd63) >> 6;
    if (need == 0) need = 1;
    for (int i = 0; i < seg_count; i++) begin
      if (!seg_used[i] && {38'b0, seg_units[i]} >= need) begin
        if ({38'b0, seg_units[i]} != need) begin
          if (seg_count >= MAX_SEGMENTS) return r;
          for (int j = seg_count; j > i + 1; j--) begin
            seg_units[j] = seg_units[j-1];
            seg_used[j] = seg_used[j-1];
          end
          seg_units[i+1] = seg_units[i] - need[ffha_pkg::UNIT_W-1:0];
          seg_used[i+1] = 1'b0;
          seg_units[i] = need[ffha_pkg::UNIT_W-1:0];
          seg_count++;
        end
        seg_used[i] = 1'b1;
        r.addr = addr[31:0];
        r.ok = 1'b1;
        return r;
      end
      addr += {38'b0, seg_units[i]} << 6;
    end
    if (seg_count >= MAX_SEGMENTS || addr + (need << 6) >= 64'h1_0000_0000) return r;
    seg_units[seg_count] = need[ffha_pkg::UNIT_W-1:0];
    seg_used[seg_count] = 1'b1;
    seg_count++;
    r.addr = addr[31:0];
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic heap_reply_t release_segment(logic [31:0] target);
    heap_reply_t r;
    logic [63:0] addr;
    r = '0;
    addr = {32'b0, heap_base};
    if (target == 0) begin
      r.ok = 1'b1;
      return r;
    end
    for (int i = 0; i < seg_count; i++) begin
      if (seg_used[i] && addr == {32'b0, target}) begin
        seg_used[i] = 1'b0;
        if (i > 0 && !seg_used[i-1]) begin
          seg_units[i-1] += seg_units[i];
          for (int j = i; j + 1 < seg_count; j++) begin
            seg_units[j] = seg_units[j+1];
            seg_used[j] = seg_used[j+1];
          end
          seg_count--;
        end
        r.ok = 1'b1;
        return r;
      end
      addr += {38'b0, seg_units[i]} << 6;
    end
    return r;
  endfunction

  assign pending = reply_q.size();

  always @(posedge clk) begin
    heap_reply_t want;
    if (rst) begin
      heap_base = '0;
      seg_count = 0;
      reply_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) heap_base = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ffha_pkg::CMD_ALLOC)
          reply_q.push_back(alloc_segment(s_axis_tdata));
        else reply_q.push_back(release_segment(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: addr %h ok %b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = reply_q.pop_front();
          if (want.addr !== m_axis_tdata || want.ok !== m_axis_tuser) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected addr %h ok %b, got addr %h ok %b",
                       want.addr, want.ok, m_axis_tdata, m_axis_tuser);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/first_fit_heap_allocator_unit_tb.sv @@
`default_nettype none
module first_fit_heap_allocator_unit_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  int          fail_count;
  int          pending;
  int          tx_idle = 0;
  int          rx_idle = 0;
  bit          hold_req = 1'b0;
  int          cycles = 0;
  logic [31:0] heap_base = '0;
  logic [31:0] live_addr[$];
  logic        sent_cmd[$];

  always #6 clk = ~clk;

  first_fit_heap_allocator_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  first_fit_heap_allocator_unit_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1_000_000) begin
      $display("status: fail");
      $finish;
    end
  end

  // learn granted addresses so releases mostly hit live segments
  always @(posedge clk) begin
    logic c;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sent_cmd.push_back(s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready && sent_cmd.size() > 0) begin
        c = sent_cmd.pop_front();
        if (c == ffha_pkg::CMD_ALLOC && m_axis_tuser) live_addr.push_back(m_axis_tdata);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !rst && ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic send_req(logic cmd, logic [31:0] value);
    if ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_and_set_base(logic [31:0] b);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    foreach (live_addr[k]) live_addr[k] = live_addr[k] + (b - heap_base);
    heap_base = b;
  endtask

  task automatic random_req();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 60 || live_addr.size() == 0) begin
      r = $urandom_range(99);
      if (r < 70) send_req(ffha_pkg::CMD_ALLOC, $urandom_range(2000));
      else if (r < 80) send_req(ffha_pkg::CMD_ALLOC, $urandom_range(1 << 20));
      else if (r < 90) send_req(ffha_pkg::CMD_ALLOC, $urandom);
      else send_req(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFC0 - 100 + $urandom_range(163));
    end else begin
      r = $urandom_range(99);
      k = $urandom_range(live_addr.size() - 1);
      if (r < 80) begin
        send_req(ffha_pkg::CMD_FREE, live_addr[k]);
        live_addr.delete(k);
      end else if (r < 88) send_req(ffha_pkg::CMD_FREE, 32'h0);
      else if (r < 94) send_req(ffha_pkg::CMD_FREE, live_addr[k] + $urandom_range(1, 63));
      else send_req(ffha_pkg::CMD_FREE, $urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle = 10;
    rx_idle = 76;
    send_req(ffha_pkg::CMD_ALLOC, 32'h0);
    send_req(ffha_pkg::CMD_ALLOC, 32'h1);
    send_req(ffha_pkg::CMD_ALLOC, 32'd64);
    send_req(ffha_pkg::CMD_ALLOC, 32'd65);
    send_req(ffha_pkg::CMD_ALLOC, 32'd640);
    send_req(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFC0);
    send_req(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFC1);
    send_req(ffha_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
    send_req(ffha_pkg::CMD_FREE, 32'h0);
    send_req(ffha_pkg::CMD_FREE, 32'd128);
    send_req(ffha_pkg::CMD_FREE, 32'd128);
    send_req(ffha_pkg::CMD_FREE, 32'd12345);
    send_req(ffha_pkg::CMD_FREE, 32'hFFFF_FFFF);
    send_req(ffha_pkg::CMD_FREE, 32'd64);
    send_req(ffha_pkg::CMD_ALLOC, 32'd100);
    send_req(ffha_pkg::CMD_FREE, 32'd256);
    send_req(ffha_pkg::CMD_ALLOC, 32'd64);
    send_req(ffha_pkg::CMD_ALLOC, 32'd63);
    send_req(ffha_pkg::CMD_FREE, 32'd64);
    send_req(ffha_pkg::CMD_ALLOC, 32'hFFFF_0000);
    live_addr.delete();

    drain_and_set_base(32'hFFFF_C000);
    repeat (530) random_req();

    tx_idle = 76;
    rx_idle = 10;
    drain_and_set_base(32'hFFFF_FFFF);
    repeat (100) random_req();
    drain_and_set_base(32'h0);
    repeat (430) random_req();

    tx_idle = 0;
    rx_idle = 0;
    drain_and_set_base($urandom);
    repeat (100) random_req();
    hold_req = 1'b1;
    repeat (430) random_req();

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
